>>> src/stun_attribute_parser_defines.svh
// Assertion macros for the STUN attribute parser.
// Included by the top level; no other dependencies.
`ifndef STUN_ATTRIBUTE_PARSER_DEFINES_SVH
`define STUN_ATTRIBUTE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STAP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define STAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/stap_pkg.sv
// Types, attribute codes and helpers shared by the STUN attribute parser.
// No dependencies.
`timescale 1ns / 1ps

package stap_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_VALUE  = 2'd1,
        PH_PAD    = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        KIND_DONE        = 4'd0,
        KIND_MAPPED      = 4'd1,
        KIND_XOR_MAPPED  = 4'd2,
        KIND_ALT_SERVER  = 4'd3,
        KIND_ERROR_CODE  = 4'd4,
        KIND_UNKNOWN     = 4'd5,
        KIND_TEXT        = 4'd6,
        KIND_INTEGRITY   = 4'd7,
        KIND_FINGERPRINT = 4'd8,
        KIND_LEN_ERR     = 4'd9
    } kind_t;

    localparam logic [15:0] T_MAPPED      = 16'h0001;
    localparam logic [15:0] T_USERNAME    = 16'h0006;
    localparam logic [15:0] T_INTEGRITY   = 16'h0008;
    localparam logic [15:0] T_ERROR       = 16'h0009;
    localparam logic [15:0] T_UNKNOWN     = 16'h000A;
    localparam logic [15:0] T_REALM       = 16'h0014;
    localparam logic [15:0] T_NONCE       = 16'h0015;
    localparam logic [15:0] T_XOR_MAPPED  = 16'h0020;
    localparam logic [15:0] T_SOFTWARE    = 16'h8022;
    localparam logic [15:0] T_ALT_SERVER  = 16'h8023;
    localparam logic [15:0] T_FINGERPRINT = 16'h8028;

    localparam logic [31:0] MAGIC_COOKIE       = 32'h2112A442;
    localparam logic [15:0] INTEGRITY_BYTES    = 16'd20;
    localparam logic [9:0]  TEXT_LIMIT_DEFAULT = 10'd763;
    localparam logic [15:0] FAMILY_IPV4        = 16'h0001;

    typedef struct packed {
        logic [15:0] attr_type;
        kind_t       item_kind;
        logic [15:0] port;
        logic [31:0] address;
        logic [31:0] value;
        logic        attr_done;
        logic [16:0] consumed_length;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
    } step_out_t;

    function automatic logic is_text(input logic [15:0] t);
        is_text = (t == T_REALM) || (t == T_NONCE) || (t == T_SOFTWARE);
    endfunction

    function automatic logic [1:0] pad_of(input logic [15:0] len);
        pad_of = 2'(3'd4 - {1'b0, len[1:0]});
    endfunction

endpackage

>>> src/stap_if.sv
// Valid/ready channel interfaces for the STUN attribute parser.
// No dependencies.
`timescale 1ns / 1ps

interface stap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface stap_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] attr_type;
    logic [3:0]  item_kind;
    logic [15:0] port;
    logic [31:0] address;
    logic [31:0] value;
    logic        attr_done;
    logic [16:0] consumed_length;

    modport source (output valid, output attr_type, output item_kind, output port,
                    output address, output value, output attr_done,
                    output consumed_length, input ready);
    modport sink (input valid, input attr_type, input item_kind, input port,
                  input address, input value, input attr_done,
                  input consumed_length, output ready);
endinterface

>>> src/stap_core.sv
// Parser state machine and per-byte attribute decode.
// Depends on stap_pkg.
`timescale 1ns / 1ps

module stap_core #(
    parameter int MAX_UNKNOWN_TYPES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                restart,
    input  logic [9:0]          text_length_limit,
    output stap_pkg::step_out_t step_out
);

    localparam int CntW = $clog2(MAX_UNKNOWN_TYPES + 1);

    stap_pkg::phase_t phase_reg, phase_next;
    logic [16:0] byte_position_reg, byte_position_next;
    logic [15:0] current_type_reg, current_type_next;
    logic [15:0] current_length_reg, current_length_next;
    logic [31:0] field_shift_reg, field_shift_next;
    logic [15:0] held_port_reg, held_port_next;
    logic        family_ok_reg, family_ok_next;
    logic [CntW-1:0] unknown_count_reg, unknown_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= stap_pkg::PH_HEADER;
            byte_position_reg  <= '0;
            current_type_reg   <= '0;
            current_length_reg <= '0;
            field_shift_reg    <= '0;
            held_port_reg      <= '0;
            family_ok_reg      <= 1'b0;
            unknown_count_reg  <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            byte_position_reg  <= byte_position_next;
            current_type_reg   <= current_type_next;
            current_length_reg <= current_length_next;
            field_shift_reg    <= field_shift_next;
            held_port_reg      <= held_port_next;
            family_ok_reg      <= family_ok_next;
            unknown_count_reg  <= unknown_count_next;
        end
    end

    stap_pkg::phase_t ph;
    logic [16:0] bp;
    logic [16:0] bp_inc;
    logic [16:0] v;
    logic [16:0] total;
    logic [31:0] fs_new;
    logic [9:0]  err_code;
    logic        over_long;

    always_comb
    begin
        phase_next          = phase_reg;
        byte_position_next  = byte_position_reg;
        current_type_next   = current_type_reg;
        current_length_next = current_length_reg;
        field_shift_next    = field_shift_reg;
        held_port_next      = held_port_reg;
        family_ok_next      = family_ok_reg;
        unknown_count_next  = unknown_count_reg;

        ph       = restart ? stap_pkg::PH_HEADER : phase_reg;
        bp       = restart ? 17'd0 : byte_position_reg;
        fs_new   = {field_shift_reg[23:0], data_byte};
        bp_inc   = bp + 17'd1;
        v        = bp - 17'd4;
        total    = 17'd4 + {1'b0, current_length_reg}
                   + {15'd0, stap_pkg::pad_of(current_length_reg)};
        err_code = 10'({7'd0, fs_new[10:8]} * 10'd100) + {2'd0, fs_new[7:0]};
        over_long = ((current_type_reg == stap_pkg::T_INTEGRITY)
                        && (fs_new[15:0] > stap_pkg::INTEGRITY_BYTES))
                    || (stap_pkg::is_text(current_type_reg)
                        && (fs_new[15:0] > {6'd0, text_length_limit}));

        step_out                     = '0;
        step_out.res.attr_type       = current_type_reg;
        step_out.res.item_kind       = stap_pkg::KIND_DONE;

        if (step && (ph != stap_pkg::PH_HALT))
        begin
            phase_next         = ph;
            byte_position_next = bp;
            field_shift_next   = fs_new;
            if (ph == stap_pkg::PH_HEADER)
            begin
                if (bp == 17'd1)
                    current_type_next = fs_new[15:0];
                if (bp < 17'd3)
                    byte_position_next = bp_inc;
                else
                begin
                    current_length_next = fs_new[15:0];
                    if (over_long)
                    begin
                        phase_next             = stap_pkg::PH_HALT;
                        byte_position_next     = '0;
                        step_out.emit          = 1'b1;
                        step_out.res.item_kind = stap_pkg::KIND_LEN_ERR;
                    end
                    else if (fs_new[15:0] == 16'd0)
                    begin
                        byte_position_next           = '0;
                        step_out.emit                = 1'b1;
                        step_out.res.attr_done       = 1'b1;
                        step_out.res.consumed_length = 17'd4;
                    end
                    else
                    begin
                        phase_next         = stap_pkg::PH_VALUE;
                        byte_position_next = 17'd4;
                        field_shift_next   = '0;
                        family_ok_next     = 1'b0;
                        if (current_type_reg == stap_pkg::T_UNKNOWN)
                            unknown_count_next = '0;
                    end
                end
            end
            else
            begin
                if (ph == stap_pkg::PH_VALUE)
                begin
                    unique case (current_type_reg)
                        stap_pkg::T_MAPPED, stap_pkg::T_XOR_MAPPED, stap_pkg::T_ALT_SERVER:
                        begin
                            if (v == 17'd1)
                                family_ok_next = (fs_new[15:0] == stap_pkg::FAMILY_IPV4);
                            else if (v == 17'd3)
                                held_port_next = fs_new[15:0];
                            else if ((v == 17'd7) && family_ok_reg)
                            begin
                                step_out.emit        = 1'b1;
                                step_out.res.port    = held_port_reg;
                                step_out.res.address = fs_new;
                                if (current_type_reg == stap_pkg::T_MAPPED)
                                    step_out.res.item_kind = stap_pkg::KIND_MAPPED;
                                else if (current_type_reg == stap_pkg::T_XOR_MAPPED)
                                begin
                                    step_out.res.item_kind = stap_pkg::KIND_XOR_MAPPED;
                                    step_out.res.port    = held_port_reg
                                                           ^ stap_pkg::MAGIC_COOKIE[31:16];
                                    step_out.res.address = fs_new ^ stap_pkg::MAGIC_COOKIE;
                                end
                                else
                                    step_out.res.item_kind = stap_pkg::KIND_ALT_SERVER;
                            end
                        end
                        stap_pkg::T_ERROR:
                        begin
                            if (v == 17'd3)
                            begin
                                step_out.emit          = 1'b1;
                                step_out.res.item_kind = stap_pkg::KIND_ERROR_CODE;
                                step_out.res.value     = {22'd0, err_code};
                            end
                            else if (v > 17'd3)
                            begin
                                step_out.emit          = 1'b1;
                                step_out.res.item_kind = stap_pkg::KIND_TEXT;
                                step_out.res.value     = {24'd0, data_byte};
                            end
                        end
                        stap_pkg::T_UNKNOWN:
                        begin
                            if (v[0] && (unknown_count_reg < CntW'(MAX_UNKNOWN_TYPES)))
                            begin
                                step_out.emit          = 1'b1;
                                step_out.res.item_kind = stap_pkg::KIND_UNKNOWN;
                                step_out.res.value     = {16'd0, fs_new[15:0]};
                                unknown_count_next     = unknown_count_reg + CntW'(1);
                            end
                        end
                        stap_pkg::T_USERNAME, stap_pkg::T_REALM, stap_pkg::T_NONCE,
                        stap_pkg::T_SOFTWARE:
                        begin
                            step_out.emit          = 1'b1;
                            step_out.res.item_kind = stap_pkg::KIND_TEXT;
                            step_out.res.value     = {24'd0, data_byte};
                        end
                        stap_pkg::T_INTEGRITY:
                        begin
                            step_out.emit          = 1'b1;
                            step_out.res.item_kind = stap_pkg::KIND_INTEGRITY;
                            step_out.res.value     = {24'd0, data_byte};
                        end
                        stap_pkg::T_FINGERPRINT:
                        begin
                            if (v == 17'd3)
                            begin
                                step_out.emit          = 1'b1;
                                step_out.res.item_kind = stap_pkg::KIND_FINGERPRINT;
                                step_out.res.value     = fs_new;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if ((v + 17'd1) >= {1'b0, current_length_reg})
                        phase_next = stap_pkg::PH_PAD;
                end
                byte_position_next = bp_inc;
                if (bp_inc >= total)
                begin
                    phase_next                   = stap_pkg::PH_HEADER;
                    byte_position_next           = '0;
                    step_out.emit                = 1'b1;
                    step_out.res.attr_done       = 1'b1;
                    step_out.res.consumed_length = total;
                end
            end
        end
    end

endmodule

>>> src/stun_attribute_parser.sv
// A registered result shows in the cycle after the transfer of the byte that causes it.
// Throughput: one byte per cycle while the output is not stalled; the parser state
// updates in a single pass per byte and a one-entry result register decouples the
// output side. Reset: parser returns to the header phase with all state cleared,
// output empty, text_length_limit set to 763.
// Top level of the STUN attribute parser; depends on stap_pkg, stap_if, stap_core.
`timescale 1ns / 1ps
`include "stun_attribute_parser_defines.svh"

module stun_attribute_parser #(
    parameter int MAX_UNKNOWN_TYPES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [9:0]  cfg_write_data,
    stap_in_if.sink     in_ch,
    stap_out_if.source  out_ch
);

    logic [9:0] text_length_limit_reg;
    logic       out_valid_reg, out_valid_next;
    stap_pkg::result_t out_data_reg, out_data_next;
    stap_pkg::step_out_t step_out;
    logic in_transfer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_length_limit_reg <= stap_pkg::TEXT_LIMIT_DEFAULT;
        else if (cfg_write_en)
            text_length_limit_reg <= cfg_write_data;
    end

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_transfer = in_ch.valid && in_ch.ready;

    stap_core #(
        .MAX_UNKNOWN_TYPES (MAX_UNKNOWN_TYPES)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (in_transfer),
        .data_byte         (in_ch.data_byte),
        .restart           (in_ch.restart),
        .text_length_limit (text_length_limit_reg),
        .step_out          (step_out)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;
        if (in_transfer && step_out.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = step_out.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.attr_type       = out_data_reg.attr_type;
    assign out_ch.item_kind       = out_data_reg.item_kind;
    assign out_ch.port            = out_data_reg.port;
    assign out_ch.address         = out_data_reg.address;
    assign out_ch.value           = out_data_reg.value;
    assign out_ch.attr_done       = out_data_reg.attr_done;
    assign out_ch.consumed_length = out_data_reg.consumed_length;

    `STAP_ASSERT_NEXT(a_result_loaded, clk, rst_n, in_transfer && step_out.emit, out_valid_reg, "result of a transfer was not registered")
    `STAP_ASSERT_IMPLIES(a_len_err_not_done, clk, rst_n, out_valid_reg && (out_data_reg.item_kind == stap_pkg::KIND_LEN_ERR), !out_data_reg.attr_done, "length error marked as attribute end")
    `STAP_ASSERT_IMPLIES(a_consumed_aligned, clk, rst_n, out_valid_reg && out_data_reg.attr_done, (out_data_reg.consumed_length[1:0] == 2'd0) && (out_data_reg.consumed_length >= 17'd4), "consumed length not a padded attribute size")
    `STAP_ASSERT_IMPLIES(a_consumed_idle, clk, rst_n, out_valid_reg && !out_data_reg.attr_done, out_data_reg.consumed_length == 17'd0, "consumed length set without attribute end")

endmodule

>>> dv/tb.sv
// Self-checking bench for stun_attribute_parser: streams attribute areas byte by byte
// and checks every decoded result against a cycle-free model kept in this file.
// Depends on stap_pkg, stap_if and the parser RTL.
`timescale 1ns / 1ps

module tb;

    localparam int UNKNOWN_LIMIT = 8;
    localparam int PHASE_BYTES   = 100;

    typedef struct packed {
        logic [7:0] octet;
        logic       restart;
        logic       hold;
    } area_byte_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [9:0]  cfg_write_data;

    stap_in_if  in_ch ();
    stap_out_if out_ch ();

    stun_attribute_parser #(
        .MAX_UNKNOWN_TYPES(UNKNOWN_LIMIT)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    area_byte_t          area_bytes[$];
    stap_pkg::result_t   decoded_q[$];
    area_byte_t          next_octet;
    stap_pkg::result_t   want;
    stap_pkg::result_t   got;
    logic       in_taken;
    int         burst_left;
    int         gap_left;
    logic [15:0] stall_pattern;
    logic [3:0]  stall_phase;
    int         errors;
    int         stim_count;

    stap_pkg::phase_t parse_phase;
    logic [16:0] attr_pos;
    logic [15:0] attr_code;
    logic [15:0] attr_len;
    logic [31:0] window;
    logic [15:0] held_port;
    logic        family_ok;
    logic [3:0]  unknown_seen;
    logic [9:0]  text_limit;

    always #5 clk = ~clk;

    function automatic logic [16:0] attr_span(input logic [15:0] len);
        logic [1:0] pad;
        pad = 2'd0 - len[1:0];
        attr_span = 17'd4 + {1'b0, len} + {15'd0, pad};
    endfunction

    task automatic decode_byte(input logic [7:0] octet, input logic rs);
        stap_pkg::result_t r;
        logic        emit;
        logic        fin;
        logic [16:0] voff;
        r = '0;
        emit = 1'b0;
        fin = 1'b0;
        if (rs)
        begin
            parse_phase = stap_pkg::PH_HEADER;
            attr_pos = '0;
        end
        if (parse_phase == stap_pkg::PH_HALT)
            return;
        window = {window[23:0], octet};
        if (parse_phase == stap_pkg::PH_HEADER)
        begin
            if (attr_pos == 17'd1)
                attr_code = window[15:0];
            if (attr_pos < 17'd3)
            begin
                attr_pos = attr_pos + 17'd1;
                return;
            end
            attr_len = window[15:0];
            if ((attr_code == stap_pkg::T_INTEGRITY && attr_len > stap_pkg::INTEGRITY_BYTES) ||
                ((attr_code == stap_pkg::T_REALM || attr_code == stap_pkg::T_NONCE ||
                  attr_code == stap_pkg::T_SOFTWARE) &&
                 attr_len > {6'd0, text_limit}))
            begin
                parse_phase = stap_pkg::PH_HALT;
                attr_pos = '0;
                r.item_kind = stap_pkg::KIND_LEN_ERR;
                emit = 1'b1;
            end
            else if (attr_len == 16'd0)
                fin = 1'b1;
            else
            begin
                parse_phase = stap_pkg::PH_VALUE;
                attr_pos = 17'd4;
                window = '0;
                family_ok = 1'b0;
                if (attr_code == stap_pkg::T_UNKNOWN)
                    unknown_seen = '0;
            end
        end
        else
        begin
            voff = attr_pos - 17'd4;
            if (parse_phase == stap_pkg::PH_VALUE)
            begin
                case (attr_code)
                    stap_pkg::T_MAPPED, stap_pkg::T_XOR_MAPPED, stap_pkg::T_ALT_SERVER:
                    begin
                        if (voff == 17'd1)
                            family_ok = (window[15:0] == stap_pkg::FAMILY_IPV4);
                        else if (voff == 17'd3)
                            held_port = window[15:0];
                        else if (voff == 17'd7 && family_ok)
                        begin
                            emit = 1'b1;
                            r.port = held_port;
                            r.address = window;
                            if (attr_code == stap_pkg::T_MAPPED)
                                r.item_kind = stap_pkg::KIND_MAPPED;
                            else if (attr_code == stap_pkg::T_XOR_MAPPED)
                            begin
                                r.item_kind = stap_pkg::KIND_XOR_MAPPED;
                                r.port = held_port ^ stap_pkg::MAGIC_COOKIE[31:16];
                                r.address = window ^ stap_pkg::MAGIC_COOKIE;
                            end
                            else
                                r.item_kind = stap_pkg::KIND_ALT_SERVER;
                        end
                    end
                    stap_pkg::T_ERROR:
                    begin
                        if (voff == 17'd3)
                        begin
                            emit = 1'b1;
                            r.item_kind = stap_pkg::KIND_ERROR_CODE;
                            r.value = 32'(window[10:8]) * 32'd100 + 32'(window[7:0]);
                        end
                        else if (voff > 17'd3)
                        begin
                            emit = 1'b1;
                            r.item_kind = stap_pkg::KIND_TEXT;
                            r.value = {24'd0, octet};
                        end
                    end
                    stap_pkg::T_UNKNOWN:
                    begin
                        if (voff[0] && unknown_seen < UNKNOWN_LIMIT)
                        begin
                            emit = 1'b1;
                            r.item_kind = stap_pkg::KIND_UNKNOWN;
                            r.value = {16'd0, window[15:0]};
                            unknown_seen = unknown_seen + 4'd1;
                        end
                    end
                    stap_pkg::T_USERNAME, stap_pkg::T_REALM, stap_pkg::T_NONCE,
                    stap_pkg::T_SOFTWARE:
                    begin
                        emit = 1'b1;
                        r.item_kind = stap_pkg::KIND_TEXT;
                        r.value = {24'd0, octet};
                    end
                    stap_pkg::T_INTEGRITY:
                    begin
                        emit = 1'b1;
                        r.item_kind = stap_pkg::KIND_INTEGRITY;
                        r.value = {24'd0, octet};
                    end
                    stap_pkg::T_FINGERPRINT:
                    begin
                        if (voff == 17'd3)
                        begin
                            emit = 1'b1;
                            r.item_kind = stap_pkg::KIND_FINGERPRINT;
                            r.value = window;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (voff + 17'd1 >= {1'b0, attr_len})
                    parse_phase = stap_pkg::PH_PAD;
            end
            attr_pos = attr_pos + 17'd1;
            if (attr_pos >= attr_span(attr_len))
                fin = 1'b1;
        end
        if (fin)
        begin
            r.attr_done = 1'b1;
            r.consumed_length = attr_span(attr_len);
            parse_phase = stap_pkg::PH_HEADER;
            attr_pos = '0;
        end
        if (emit || fin)
        begin
            r.attr_type = attr_code;
            decoded_q.push_back(r);
        end
    endtask

    task automatic push_octet(input logic [7:0] b, input logic rs, input logic hold);
        area_bytes.push_back('{octet: b, restart: rs, hold: hold});
    endtask

    task automatic push_attr(input logic [15:0] atype, input int len, input logic rs,
                             input logic hold, output bit halted);
        int         i;
        int         pad;
        logic [7:0] b;
        bit         ipv4;
        halted = (atype == stap_pkg::T_INTEGRITY && len > stap_pkg::INTEGRITY_BYTES) ||
                 ((atype == stap_pkg::T_REALM || atype == stap_pkg::T_NONCE ||
                   atype == stap_pkg::T_SOFTWARE) &&
                  len > text_limit);
        push_octet(atype[15:8], rs, hold);
        push_octet(atype[7:0], 1'b0, 1'b0);
        push_octet(8'(len >> 8), 1'b0, 1'b0);
        push_octet(8'(len), 1'b0, 1'b0);
        stim_count += 4;
        if (halted)
        begin
            // drop a few bytes into the halted parser
            repeat ($urandom_range(1, 3))
                push_octet(8'($urandom), 1'b0, 1'b0);
            return;
        end
        ipv4 = ($urandom_range(0, 4) != 0);
        pad = (4 - (len % 4)) % 4;
        for (i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            if ((atype == stap_pkg::T_MAPPED || atype == stap_pkg::T_XOR_MAPPED ||
                 atype == stap_pkg::T_ALT_SERVER) && ipv4 && i < 2)
                b = (i == 0) ? stap_pkg::FAMILY_IPV4[15:8] : stap_pkg::FAMILY_IPV4[7:0];
            push_octet(b, 1'b0, 1'b0);
        end
        for (i = 0; i < pad; i++)
            push_octet(8'($urandom), 1'b0, 1'b0);
        stim_count += len + pad;
    endtask

    task automatic push_area(input int budget);
        int          used;
        int          len;
        int          start;
        int          cut;
        logic [15:0] atype;
        bit          halted;
        logic        first;
        first = 1'b1;
        used = 0;
        while (used < budget)
        begin
            case ($urandom_range(0, 11))
                0:       atype = stap_pkg::T_MAPPED;
                1:       atype = stap_pkg::T_XOR_MAPPED;
                2:       atype = stap_pkg::T_ALT_SERVER;
                3:       atype = stap_pkg::T_ERROR;
                4:       atype = stap_pkg::T_UNKNOWN;
                5:       atype = stap_pkg::T_USERNAME;
                6:       atype = stap_pkg::T_REALM;
                7:       atype = stap_pkg::T_NONCE;
                8:       atype = stap_pkg::T_SOFTWARE;
                9:       atype = stap_pkg::T_INTEGRITY;
                10:      atype = stap_pkg::T_FINGERPRINT;
                default: atype = 16'($urandom);
            endcase
            if (atype == stap_pkg::T_MAPPED || atype == stap_pkg::T_XOR_MAPPED ||
                atype == stap_pkg::T_ALT_SERVER)
                len = ($urandom_range(0, 3) != 0) ? 8 : $urandom_range(0, 12);
            else if (atype == stap_pkg::T_ERROR)
                len = $urandom_range(0, 12);
            else if (atype == stap_pkg::T_UNKNOWN)
                len = $urandom_range(0, 20);
            else if (atype == stap_pkg::T_FINGERPRINT)
                len = ($urandom_range(0, 2) != 0) ? 4 : $urandom_range(0, 7);
            else if (atype == stap_pkg::T_INTEGRITY)
            begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(65535, 21);
                else
                    len = ($urandom_range(0, 1) != 0) ? 20 : $urandom_range(0, 20);
            end
            else if (atype == stap_pkg::T_REALM || atype == stap_pkg::T_NONCE ||
                     atype == stap_pkg::T_SOFTWARE)
            begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(65535, int'(text_limit) + 1);
                else
                    len = $urandom_range(0, (text_limit < 12) ? int'(text_limit) : 12);
            end
            else
                len = $urandom_range(0, 8);
            start = area_bytes.size();
            push_attr(atype, len, first, first && ($urandom_range(0, 9) == 0), halted);
            first = 1'b0;
            used += area_bytes.size() - start;
            if (halted)
                break;
            if ($urandom_range(0, 15) == 0)
            begin
                // cut the attribute short; the next area resyncs the parser
                cut = $urandom_range(1, 3);
                if (cut > area_bytes.size() - start - 1)
                    cut = area_bytes.size() - start - 1;
                repeat (cut)
                    void'(area_bytes.pop_back());
                break;
            end
        end
    endtask

    task automatic wait_drained();
        while (area_bytes.size() != 0 || in_ch.valid || decoded_q.size() != 0)
            @(negedge clk);
        repeat (6)
            @(negedge clk);
    endtask

    task automatic set_text_limit(input int limit);
        wait_drained();
        cfg_write_en <= 1'b1;
        cfg_write_data <= 10'(limit);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        text_limit = 10'(limit);
    endtask

    always @(negedge clk)
    begin
        if (in_ch.valid && !in_taken)
        begin
            // hold the byte until it transfers
        end
        else if (gap_left != 0)
        begin
            in_ch.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (area_bytes.size() != 0 && !(area_bytes[0].hold && decoded_q.size() != 0))
        begin
            next_octet = area_bytes.pop_front();
            in_ch.valid <= 1'b1;
            in_ch.data_byte <= next_octet.octet;
            in_ch.restart <= next_octet.restart;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            in_ch.valid <= 1'b0;
    end

    always @(negedge clk)
    begin
        out_ch.ready <= stall_pattern[stall_phase];
        stall_phase <= stall_phase + 4'd1;
        if (stall_phase == 4'hF && $urandom_range(0, 3) == 0)
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF :
                             (16'($urandom) | 16'h0001);
    end

    always @(posedge clk)
    begin
        in_taken <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
            decode_byte(in_ch.data_byte, in_ch.restart);
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.attr_type, out_ch.item_kind, out_ch.port, out_ch.address,
                   out_ch.value, out_ch.attr_done, out_ch.consumed_length};
            if (decoded_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result type=%h kind=%0d port=%h addr=%h val=%h done=%b len=%0d",
                             $time, got.attr_type, got.item_kind, got.port, got.address,
                             got.value, got.attr_done, got.consumed_length);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t: expected type=%h kind=%0d port=%h addr=%h val=%h done=%b len=%0d",
                                 $time, want.attr_type, want.item_kind, want.port, want.address,
                                 want.value, want.attr_done, want.consumed_length);
                        $display("%0t: actual   type=%h kind=%0d port=%h addr=%h val=%h done=%b len=%0d",
                                 $time, got.attr_type, got.item_kind, got.port, got.address,
                                 got.value, got.attr_done, got.consumed_length);
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [7:0] directed [25];
        int         limits [4];
        int         p;
        int         target;
        bit         halted;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.restart = 1'b0;
        out_ch.ready = 1'b0;
        in_taken = 1'b0;
        burst_left = 1;
        gap_left = 0;
        stall_pattern = 16'hFFFF;
        stall_phase = '0;
        errors = 0;
        stim_count = 0;
        parse_phase = stap_pkg::PH_HEADER;
        attr_pos = '0;
        attr_code = '0;
        attr_len = '0;
        window = '0;
        held_port = '0;
        family_ok = 1'b0;
        unknown_seen = '0;
        text_limit = stap_pkg::TEXT_LIMIT_DEFAULT;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero-length attribute, error code ending on its last byte,
        // over-long integrity with an ignored byte, fingerprint after a restart
        directed = '{8'hFF, 8'hFF, 8'h00, 8'h00,
                     8'h00, 8'h09, 8'h00, 8'h04, 8'h00, 8'h00, 8'h07, 8'h63,
                     8'h00, 8'h08, 8'h00, 8'h15, 8'h5A,
                     8'h80, 8'h28, 8'h00, 8'h04, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
        for (p = 0; p < 25; p++)
            push_octet(directed[p], p == 0 || p == 17, p == 17);

        limits = '{1023, 0, $urandom_range(1, 24), $urandom_range(0, 1023)};
        for (p = 0; p < 4; p++)
        begin
            set_text_limit(limits[p]);
            if (limits[p] <= 40)
            begin
                push_attr(stap_pkg::T_REALM, limits[p], 1'b1, 1'b0, halted);
                push_attr(stap_pkg::T_NONCE, limits[p] + 1, 1'b0, 1'b0, halted);
            end
            else
                push_attr(stap_pkg::T_SOFTWARE, limits[p] + 1, 1'b1, 1'b0, halted);
            target = stim_count + PHASE_BYTES;
            while (stim_count < target)
                push_area($urandom_range(8, 60));
        end

        wait_drained();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
